>>> sv/mark_bitmap_block_sweeper_macros.svh
// Assertion macros used by the block sweeper top level.
`ifndef MARK_BITMAP_BLOCK_SWEEPER_MACROS_SVH
`define MARK_BITMAP_BLOCK_SWEEPER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MBBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MBBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mbbs_pkg.sv
// Types, codes and the microcode program of the block sweeper.
`default_nettype none
package mbbs_pkg;

  localparam int unsigned MAX_RESULTS    = 63;
  localparam int unsigned FREE_BYTES_MAX = 2047;
  localparam int unsigned FREE_BYTES_W   = 11;
  localparam int unsigned CFG_DATA_W     = 7;

  // Input commands.
  localparam logic [2:0] CMD_SET_MARK    = 3'd0;
  localparam logic [2:0] CMD_CLR_MARK    = 3'd1;
  localparam logic [2:0] CMD_SWEEP_FL    = 3'd2;
  localparam logic [2:0] CMD_SWEEP_ONLY  = 3'd3;
  localparam logic [2:0] CMD_CANON_BEGIN = 3'd4;
  localparam logic [2:0] CMD_CANON_FREE  = 3'd5;
  localparam logic [2:0] CMD_CANON_END   = 3'd6;
  localparam logic [2:0] CMD_ALLOCATED   = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_DTOR  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  // Block phases.
  localparam logic [1:0] PHASE_NEW        = 2'd0;
  localparam logic [1:0] PHASE_FREELISTED = 2'd1;
  localparam logic [1:0] PHASE_MARKED     = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_ATOMS_PER_CELL = 1'b0;
  localparam logic CFG_NEED_DTOR      = 1'b1;

  // Sequencer step addresses.
  localparam logic [3:0] STEP_CLEAR    = 4'd0;
  localparam logic [3:0] STEP_IDLE     = 4'd1;
  localparam logic [3:0] STEP_CB_INIT  = 4'd2;
  localparam logic [3:0] STEP_CB_MARK  = 4'd3;
  localparam logic [3:0] STEP_EXEC     = 4'd4;
  localparam logic [3:0] STEP_SW_INIT  = 4'd5;
  localparam logic [3:0] STEP_SW_READ  = 4'd6;
  localparam logic [3:0] STEP_SW_EVAL  = 4'd7;
  localparam logic [3:0] STEP_SW_BYTES = 4'd8;
  localparam logic [3:0] STEP_SW_FIN   = 4'd9;
  localparam logic [3:0] STEP_EMPTY    = 4'd10;

  // Datapath operations selected by a control word.
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_CLEAR    = 4'd1;
  localparam logic [3:0] OP_WAIT_IN  = 4'd2;
  localparam logic [3:0] OP_CB_INIT  = 4'd3;
  localparam logic [3:0] OP_CB_MARK  = 4'd4;
  localparam logic [3:0] OP_EXEC     = 4'd5;
  localparam logic [3:0] OP_SW_INIT  = 4'd6;
  localparam logic [3:0] OP_SW_READ  = 4'd7;
  localparam logic [3:0] OP_SW_EVAL  = 4'd8;
  localparam logic [3:0] OP_SW_BYTES = 4'd9;
  localparam logic [3:0] OP_SW_FIN   = 4'd10;
  localparam logic [3:0] OP_EMPTY    = 4'd11;

  // Jump conditions.
  localparam logic [2:0] COND_NEVER       = 3'd0;
  localparam logic [2:0] COND_ALWAYS      = 3'd1;
  localparam logic [2:0] COND_CLEAR_MORE  = 3'd2;
  localparam logic [2:0] COND_DISPATCH    = 3'd3;
  localparam logic [2:0] COND_CANON_SKIP  = 3'd4;
  localparam logic [2:0] COND_FIT         = 3'd5;
  localparam logic [2:0] COND_NO_FIT      = 3'd6;
  localparam logic [2:0] COND_SWEEP_SKIP  = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] atom_index;
  } in_t;

  typedef struct packed {
    logic [1:0]              result_kind;
    logic [5:0]              cell_atom;
    logic                    run_destructor;
    logic [FREE_BYTES_W-1:0] free_bytes;
    logic                    last_of_run;
    logic [1:0]              block_phase;
  } out_t;

  // One control word of the program.
  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cond;
    logic [3:0] target;
  } ucw_t;

  // Status the datapath hands to the sequencer.
  typedef struct packed {
    logic       clear_more;
    logic       canon_skip;
    logic       fit;
    logic       sweep_skip;
    logic [2:0] cmd;
    logic       hold;
  } seq_flags_t;

  // The program: a taken jump goes to target (a dispatch jump to the command's entry step), otherwise to the next step.
  function automatic ucw_t ucode_rom(input logic [3:0] step);
    ucw_t w;
    unique case (step)
      STEP_CLEAR:    w = '{op: OP_CLEAR,    cond: COND_CLEAR_MORE, target: STEP_CLEAR};
      STEP_IDLE:     w = '{op: OP_WAIT_IN,  cond: COND_DISPATCH,   target: STEP_IDLE};
      STEP_CB_INIT:  w = '{op: OP_CB_INIT,  cond: COND_CANON_SKIP, target: STEP_EXEC};
      STEP_CB_MARK:  w = '{op: OP_CB_MARK,  cond: COND_FIT,        target: STEP_CB_MARK};
      STEP_EXEC:     w = '{op: OP_EXEC,     cond: COND_ALWAYS,     target: STEP_IDLE};
      STEP_SW_INIT:  w = '{op: OP_SW_INIT,  cond: COND_SWEEP_SKIP, target: STEP_EMPTY};
      STEP_SW_READ:  w = '{op: OP_SW_READ,  cond: COND_NO_FIT,     target: STEP_SW_BYTES};
      STEP_SW_EVAL:  w = '{op: OP_SW_EVAL,  cond: COND_ALWAYS,     target: STEP_SW_READ};
      STEP_SW_BYTES: w = '{op: OP_SW_BYTES, cond: COND_NEVER,      target: STEP_IDLE};
      STEP_SW_FIN:   w = '{op: OP_SW_FIN,   cond: COND_ALWAYS,     target: STEP_IDLE};
      STEP_EMPTY:    w = '{op: OP_EMPTY,    cond: COND_ALWAYS,     target: STEP_IDLE};
      default:       w = '{op: OP_NOP,      cond: COND_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Entry step of each command.
  function automatic logic [3:0] dispatch(input logic [2:0] cmd);
    logic [3:0] s;
    unique case (cmd) inside
      CMD_SWEEP_FL, CMD_SWEEP_ONLY: s = STEP_SW_INIT;
      CMD_CANON_BEGIN:              s = STEP_CB_INIT;
      default:                      s = STEP_EXEC;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> sv/mbbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mbbs_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and read register; read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/mbbs_seq.sv
// Microcode sequencer of the block sweeper: step counter, program table and jumps.
`default_nettype none
module mbbs_seq import mbbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_flags_t flags_i,
  output ucw_t       ucw_o,
  output logic [3:0] step_o
);

  logic [3:0] step_q, step_d;
  ucw_t       ucw;
  logic       take;

  assign ucw = ucode_rom(step_q);

  // Jump condition select and next step.
  always_comb begin
    unique case (ucw.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_CLEAR_MORE: take = flags_i.clear_more;
      COND_DISPATCH:   take = 1'b1;
      COND_CANON_SKIP: take = flags_i.canon_skip;
      COND_FIT:        take = flags_i.fit;
      COND_NO_FIT:     take = !flags_i.fit;
      COND_SWEEP_SKIP: take = flags_i.sweep_skip;
      default:         take = 1'b0;
    endcase
    if (flags_i.hold) begin
      step_d = step_q;
    end else if (take) begin
      step_d = (ucw.cond == COND_DISPATCH) ? dispatch(flags_i.cmd) : ucw.target;
    end else begin
      step_d = step_q + 4'd1;
    end
  end

  // Step counter; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_CLEAR;
    end else begin
      step_q <= step_d;
    end
  end

  assign ucw_o  = ucw;
  assign step_o = step_q;

endmodule
`default_nettype wire

>>> sv/mark_bitmap_block_sweeper.sv
// Top level of the mark-sweep block sweeper: datapath, bitmaps and handshakes.
// After reset a clearing pass zeroes every atom of both bitmaps; no beat is taken.
// Mark, allocated, canon free and canon end go to the execute step, which emits the result.
// Canon begin marks each cell in turn, walked by the cell pointer, then executes.
// In a sweep each cell is a bitmap RAM read, then a decision.
// One command at a time: the next beat is taken in the cycle after the last result is issued.
`default_nettype none
`include "mark_bitmap_block_sweeper_macros.svh"
module mark_bitmap_block_sweeper import mbbs_pkg::*; #(
  parameter int unsigned ATOMS_PER_BLOCK = 64,
  parameter int unsigned FIRST_ATOM      = 1,
  parameter int unsigned ATOM_BYTES      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW     = $clog2(ATOMS_PER_BLOCK);
  localparam int unsigned XW     = $clog2(ATOMS_PER_BLOCK + 128);
  localparam int unsigned PW_RAW = XW + $clog2(ATOM_BYTES + 1);
  localparam int unsigned PW     = (PW_RAW > FREE_BYTES_W) ? PW_RAW : FREE_BYTES_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] cfg_apc_q;
  logic                  cfg_dtor_q;

  // Sequencer interface.
  ucw_t       ucw;
  logic [3:0] step;
  seq_flags_t flags;
  logic       hold;

  // Datapath registers.
  logic [XW-1:0]           cur_q, cur_d;
  logic [1:0]              phase_q, phase_d;
  logic                    canon_q, canon_d;
  logic                    was_new_q, was_new_d;
  logic                    to_fl_q, to_fl_d;
  logic [XW-1:0]           free_atoms_q, free_atoms_d;
  logic [5:0]              n_q, n_d;
  logic                    pend_v_q, pend_v_d;
  logic [5:0]              pend_atom_q, pend_atom_d;
  logic                    pend_run_q, pend_run_d;
  logic [FREE_BYTES_W-1:0] bytes_q, bytes_d;
  logic [2:0]              cmd_q, cmd_d;
  logic [5:0]              atom_q, atom_d;
  out_t                    out_q, out_d;
  logic                    out_valid_q;
  logic                    emit;

  // Bitmap RAM ports.
  logic          mark_we, mark_wdata, zap_we, zap_wdata;
  logic [AW-1:0] mark_waddr, zap_waddr;
  logic          mem_re;
  logic          mark_rd, zap_rd;

  // Derived values.
  logic [XW-1:0] apc_x;
  logic [XW-1:0] atom_x;
  logic          atom_ok;
  logic [AW-1:0] atom_addr;
  logic          fit;
  logic          out_free;
  logic          dead, run, report, push;
  logic [PW-1:0] prod;

  assign apc_x     = (cfg_apc_q == '0) ? XW'(1) : XW'(cfg_apc_q);
  assign atom_x    = XW'(atom_q);
  assign atom_ok   = atom_x < XW'(ATOMS_PER_BLOCK);
  assign atom_addr = atom_x[AW-1:0];
  assign fit       = (cur_q < XW'(ATOMS_PER_BLOCK)) && ((cur_q + apc_x) <= XW'(ATOMS_PER_BLOCK));
  assign out_free  = !out_valid_q || out_ready_i;
  assign dead      = was_new_q || !mark_rd;
  assign run       = dead && cfg_dtor_q && !was_new_q && !zap_rd;
  assign report    = dead && (n_q != 6'(MAX_RESULTS));
  assign push      = report && pend_v_q;
  assign prod      = PW'(free_atoms_q) * PW'(ATOM_BYTES);

  // Stall: a step waits for an input beat or for room in the output register.
  always_comb begin
    unique case (ucw.op)
      OP_WAIT_IN:                    hold = !in_valid_i;
      OP_EXEC, OP_SW_FIN, OP_EMPTY:  hold = !out_free;
      OP_SW_EVAL:                    hold = push && !out_free;
      default:                       hold = 1'b0;
    endcase
  end

  // Status for the jump conditions.
  always_comb begin
    flags.clear_more = cur_q != XW'(ATOMS_PER_BLOCK - 1);
    flags.canon_skip = phase_q == PHASE_MARKED;
    flags.fit        = fit;
    flags.sweep_skip = ((cmd_q == CMD_SWEEP_ONLY) && !cfg_dtor_q) ||
                       (phase_q == PHASE_FREELISTED);
    flags.cmd        = in_data_i.cmd;
    flags.hold       = hold;
  end

  mbbs_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ucw_o   (ucw),
    .step_o  (step)
  );

  // Datapath actions of the current control word.
  always_comb begin
    cur_d        = cur_q;
    phase_d      = phase_q;
    canon_d      = canon_q;
    was_new_d    = was_new_q;
    to_fl_d      = to_fl_q;
    free_atoms_d = free_atoms_q;
    n_d          = n_q;
    pend_v_d     = pend_v_q;
    pend_atom_d  = pend_atom_q;
    pend_run_d   = pend_run_q;
    bytes_d      = bytes_q;
    cmd_d        = cmd_q;
    atom_d       = atom_q;
    mark_we      = 1'b0;
    mark_wdata   = 1'b0;
    mark_waddr   = atom_addr;
    zap_we       = 1'b0;
    zap_wdata    = 1'b0;
    zap_waddr    = atom_addr;
    mem_re       = 1'b0;
    emit         = 1'b0;
    out_d        = '{result_kind: KIND_ACK, cell_atom: '0, run_destructor: 1'b0,
                     free_bytes: '0, last_of_run: 1'b1, block_phase: phase_q};
    if (!hold) begin
      unique case (ucw.op)
        OP_CLEAR: begin
          mark_we    = 1'b1;
          zap_we     = 1'b1;
          mark_waddr = cur_q[AW-1:0];
          zap_waddr  = cur_q[AW-1:0];
          cur_d      = cur_q + XW'(1);
        end
        OP_WAIT_IN: begin
          cmd_d  = in_data_i.cmd;
          atom_d = in_data_i.atom_index;
        end
        OP_CB_INIT: begin
          if (phase_q != PHASE_MARKED) begin
            cur_d   = XW'(FIRST_ATOM);
            canon_d = 1'b1;
          end
        end
        OP_CB_MARK: begin
          if (fit) begin
            mark_we    = 1'b1;
            mark_wdata = 1'b1;
            mark_waddr = cur_q[AW-1:0];
            cur_d      = cur_q + apc_x;
          end
        end
        OP_EXEC: begin
          unique case (cmd_q)
            CMD_SET_MARK: begin
              mark_we    = atom_ok;
              mark_wdata = 1'b1;
            end
            CMD_CLR_MARK: begin
              mark_we = atom_ok;
            end
            CMD_CANON_FREE: begin
              mark_we   = canon_q && atom_ok;
              zap_we    = canon_q && atom_ok;
              zap_wdata = 1'b1;
            end
            CMD_CANON_END: begin
              if (canon_q) begin
                phase_d = PHASE_MARKED;
                canon_d = 1'b0;
              end
            end
            CMD_ALLOCATED: begin
              zap_we = atom_ok;
            end
            default: begin
            end
          endcase
          emit              = 1'b1;
          out_d.block_phase = phase_d;
        end
        OP_SW_INIT: begin
          was_new_d    = phase_q == PHASE_NEW;
          to_fl_d      = (cmd_q == CMD_SWEEP_FL) || (phase_q == PHASE_NEW);
          cur_d        = XW'(FIRST_ATOM);
          free_atoms_d = '0;
          n_d          = '0;
          pend_v_d     = 1'b0;
        end
        OP_SW_READ: begin
          mem_re = fit;
        end
        OP_SW_EVAL: begin
          zap_we    = run;
          zap_wdata = 1'b1;
          zap_waddr = cur_q[AW-1:0];
          if (dead && to_fl_q) begin
            free_atoms_d = free_atoms_q + apc_x;
          end
          if (push) begin
            emit  = 1'b1;
            out_d = '{result_kind: to_fl_q ? KIND_FREE : KIND_DTOR,
                      cell_atom: pend_atom_q, run_destructor: pend_run_q,
                      free_bytes: '0, last_of_run: 1'b0, block_phase: phase_q};
          end
          if (report) begin
            pend_v_d    = 1'b1;
            pend_atom_d = cur_q[5:0];
            pend_run_d  = run;
            n_d         = n_q + 6'd1;
          end
          cur_d = cur_q + apc_x;
        end
        OP_SW_BYTES: begin
          bytes_d = (prod > PW'(FREE_BYTES_MAX)) ? FREE_BYTES_W'(FREE_BYTES_MAX)
                                                 : prod[FREE_BYTES_W-1:0];
        end
        OP_SW_FIN: begin
          phase_d = to_fl_q ? PHASE_FREELISTED : PHASE_MARKED;
          emit    = 1'b1;
          if (pend_v_q) begin
            out_d = '{result_kind: to_fl_q ? KIND_FREE : KIND_DTOR,
                      cell_atom: pend_atom_q, run_destructor: pend_run_q,
                      free_bytes: bytes_q, last_of_run: 1'b1, block_phase: phase_q};
          end else begin
            out_d.result_kind = KIND_EMPTY;
            out_d.block_phase = phase_d;
          end
        end
        OP_EMPTY: begin
          emit              = 1'b1;
          out_d.result_kind = KIND_EMPTY;
        end
        default: begin
        end
      endcase
    end
  end

  // Mark and zapped bitmaps, one bit per atom.
  mbbs_ram #(
    .WIDTH (1),
    .DEPTH (ATOMS_PER_BLOCK)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (mem_re),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (mark_rd)
  );

  mbbs_ram #(
    .WIDTH (1),
    .DEPTH (ATOMS_PER_BLOCK)
  ) u_zap_ram (
    .clk_i   (clk_i),
    .we_i    (zap_we),
    .waddr_i (zap_waddr),
    .wdata_i (zap_wdata),
    .re_i    (mem_re),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (zap_rd)
  );

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_apc_q   <= CFG_DATA_W'(1);
      cfg_dtor_q  <= 1'b0;
      cur_q       <= '0;
      phase_q     <= PHASE_NEW;
      canon_q     <= 1'b0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ATOMS_PER_CELL: cfg_apc_q  <= cfg_data_i;
          CFG_NEED_DTOR:      cfg_dtor_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      cur_q    <= cur_d;
      phase_q  <= phase_d;
      canon_q  <= canon_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    was_new_q    <= was_new_d;
    to_fl_q      <= to_fl_d;
    free_atoms_q <= free_atoms_d;
    pend_atom_q  <= pend_atom_d;
    pend_run_q   <= pend_run_d;
    bytes_q      <= bytes_d;
    cmd_q        <= cmd_d;
    atom_q       <= atom_d;
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = ucw.op == OP_WAIT_IN;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // The clearing pass never produces a result beat.
  `MBBS_ASSERT_IMP(a_clear_silent, step == STEP_CLEAR, !out_valid_q,
                   "result beat during clearing pass")
  // A pending cell is always counted among the reported cells.
  `MBBS_ASSERT_IMP(a_pend_counted, pend_v_q, n_q != '0,
                   "pending cell without a result count")
  // Bitmap reads stay inside the block.
  `MBBS_ASSERT_IMP(a_read_in_block, mem_re, cur_q < XW'(ATOMS_PER_BLOCK),
                   "sweep read past the last atom")
  // Finishing a sweep delivers a beat and returns to idle.
  `MBBS_ASSERT_NXT(a_fin_to_idle, (step == STEP_SW_FIN) && !hold,
                   (step == STEP_IDLE) && out_valid_q,
                   "sweep finish did not deliver its last beat")

endmodule
`default_nettype wire
